FILE: hw/rtl/jmb_pkg.sv
// Shared types, codes and constants of the joint-mode blend PD controller.
`default_nettype none

package jmb_pkg;

	localparam int JMB_JOINTS = 2;

	// Shared multiplier: signed a x signed b, registered product.
	localparam int MUL_AW = 36;
	localparam int MUL_BW = 22;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Shared divider: unsigned numerator / unsigned divisor, one bit a cycle.
	localparam int DIV_NW = 38;
	localparam int DIV_DW = 21;

	localparam int TIME_W = 21;

	localparam logic [19:0]       ONE_MILLION  = 20'd1000000;
	localparam logic [TIME_W-1:0] LEN_MIN      = 21'd100000;
	localparam logic [TIME_W-1:0] LEN_MAX      = 21'd2000000;
	localparam logic [TIME_W-1:0] ELAPSED_MAX  = 21'd2097151;
	localparam logic signed [15:0] DEG_LIMIT   = 16'sd11520;
	localparam logic [16:0]       DEG_TO_RAD   = 17'd73204;
	localparam logic [17:0]       SMOOTH_K     = 18'd196608;

	localparam logic [15:0] KP_RESET    = 16'd20480;
	localparam logic [15:0] KD_RESET    = 16'd2560;
	localparam logic [14:0] SPEED_RESET = 15'd4096;
	localparam logic [16:0] PERIOD_RESET = 17'd1000;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_MODE   = 2'd1,
		ACT_TARGET = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_HOLD   = 2'd0,
		MODE_OFF    = 2'd1,
		MODE_FOLLOW = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_KP_J0  = 3'd1,
		REG_KP_J1  = 3'd2,
		REG_KD_J0  = 3'd3,
		REG_KD_J1  = 3'd4,
		REG_SPEED  = 3'd5,
		REG_PERIOD = 3'd6
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_M2,
		S_RS_START,
		S_RS_DIV,
		S_RS_WAIT,
		S_RB_CHK,
		S_RB_TWAIT,
		S_RB_T2,
		S_RB_S,
		S_RB_S2,
		S_RB_DS,
		S_RB_P,
		S_RB_PW,
		S_RB_V1,
		S_RB_V2,
		S_RB_V3,
		S_TQ,
		S_TQ2,
		S_TQ3,
		S_CV,
		S_CV2,
		S_ELAPSE,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jmb_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module jmb_mul import jmb_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_AW-1:0] a,
	input  wire logic signed [MUL_BW-1:0] b,
	output logic signed [MUL_PW-1:0]      p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/jmb_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module jmb_div import jmb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIV_NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			// shift in the next numerator bit, subtract when it fits
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/joint_mode_blend_pd_controller.sv
// Top level of the joint-mode blend PD controller: sequencer, state and I/O.
`default_nettype none

// Controller for a group of up to two joints. Each input transaction carries an
// action in s_axis_tuser (tick, mode change, new target, blend reset) and the
// measured positions, velocities and target angles in s_axis_tdata; every input
// transaction yields exactly one result transaction with two saturated Q20.12
// PD torques and four status flags. Mode 0 holds a latched position, mode 1
// drives nothing, mode 2 follows targets; entering mode 0 or 2 or a new target
// starts a cubic smoothstep blend whose length is the largest joint move over
// blend_speed, clamped to 0.1..2 s. The block works on one transaction at a
// time through a small sequencer around one shared multiplier and one shared
// 38-bit restoring divider. The result waits in an output register, so the
// next transaction is taken as soon as the sequencer is idle. Configuration
// writes are always taken (cfg_ready is high) and should only be issued while
// the block is idle.

module joint_mode_blend_pd_controller import jmb_pkg::*; #(
	parameter int JOINTS = JMB_JOINTS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: mode_request[2:0], pos_j0[18:3], pos_j1[34:19], vel_j0[50:35],
	//        vel_j1[66:51], target_j0[82:67], target_j1[98:83], zero fill
	input  wire logic [103:0] s_axis_tdata,
	// tuser: action[1:0]
	input  wire logic [1:0]   s_axis_tuser,
	// result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: torque_j0[31:0], torque_j1[63:32]
	output logic [63:0]       m_axis_tdata,
	// tuser: drive_valid[0], accepted[1], blending[2], torque_clipped[3]
	output logic [3:0]        m_axis_tuser,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [16:0]  cfg_data
);

	localparam int JIW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// ---------------------------------------------------------------- config
	logic        enable_q;
	logic [15:0] kp_q [JOINTS];
	logic [15:0] kd_q [JOINTS];
	logic [14:0] speed_q;
	logic [16:0] period_q;
	logic [15:0] kp_w [2];
	logic [15:0] kd_w [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			kp_w[0]  <= KP_RESET;
			kp_w[1]  <= KP_RESET;
			kd_w[0]  <= KD_RESET;
			kd_w[1]  <= KD_RESET;
			speed_q  <= SPEED_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_KP_J0:  kp_w[0]  <= cfg_data[15:0];
				REG_KP_J1:  kp_w[1]  <= cfg_data[15:0];
				REG_KD_J0:  kd_w[0]  <= cfg_data[15:0];
				REG_KD_J1:  kd_w[1]  <= cfg_data[15:0];
				REG_SPEED:  speed_q  <= cfg_data[14:0];
				REG_PERIOD: period_q <= cfg_data;
				default: ; // unused index: drop the write
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < JOINTS; j++) begin
			kp_q[j] = kp_w[j];
			kd_q[j] = kd_w[j];
		end
	end

	// ------------------------------------------------------- sequencer state
	seq_state_t state_q, state_d;
	logic [JIW-1:0] j_q;
	logic           j_last;

	assign j_last = (j_q == JIW'(JOINTS - 1));

	// latched input transaction
	action_t            act_q;
	logic [2:0]         req_q;
	logic signed [15:0] in_pos_q [JOINTS];
	logic signed [15:0] in_vel_q [JOINTS];
	logic signed [15:0] in_tgt_q [JOINTS];

	// controller state
	mode_t              mode_q;
	logic               blend_on_q, hold_latched_q, goal_seen_q;
	logic signed [15:0] hold_pos_q     [JOINTS];
	logic signed [15:0] raw_goal_q     [JOINTS];
	logic signed [15:0] applied_goal_q [JOINTS];
	logic signed [15:0] want_pos_q     [JOINTS];
	logic signed [15:0] want_vel_q     [JOINTS];
	logic signed [15:0] blend_start_q  [JOINTS];
	logic signed [15:0] last_pos_q     [JOINTS];
	logic signed [15:0] last_vel_q     [JOINTS];
	logic [TIME_W-1:0]  len_q, elapsed_q;

	// blend scratch
	logic [15:0]        t_q;
	logic [17:0]        s_q;
	logic [16:0]        ds_q;
	logic signed [35:0] pp_q;

	// result being built
	logic signed [31:0] res_tq_q [JOINTS];
	logic               res_drive_q, res_acc_q, res_clip_q;

	// shared units
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_p;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	jmb_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	jmb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------ combinational helpers
	logic signed [15:0] goal_c      [JOINTS];
	logic signed [15:0] rst_start_c [JOINTS];
	logic [16:0]        disp_c;
	logic               any_want_c, any_last_c, changed_c;
	logic signed [16:0] diff_c;
	logic [16:0]        diff_mag_c;
	logic signed [16:0] perr_c, verr_c;
	logic signed [15:0] tgt_clamp_c;
	logic [14:0]        speed_c;
	logic               tick_restart_c;
	seq_state_t         rs_return_c;

	always_comb begin
		logic signed [16:0] d;
		logic [16:0]        m;
		disp_c     = '0;
		any_want_c = 1'b0;
		any_last_c = 1'b0;
		changed_c  = 1'b0;
		for (int j = 0; j < JOINTS; j++) begin
			// mode 0 blends toward the hold point from the last measurement
			goal_c[j]      = (mode_q == MODE_HOLD) ? hold_pos_q[j] : applied_goal_q[j];
			rst_start_c[j] = (mode_q == MODE_HOLD) ? last_pos_q[j] : want_pos_q[j];
			d = 17'(goal_c[j]) - 17'(rst_start_c[j]);
			m = d[16] ? 17'(-d) : 17'(d);
			if (m > disp_c) disp_c = m;
			if (want_pos_q[j] != '0) any_want_c = 1'b1;
			if (last_pos_q[j] != '0) any_last_c = 1'b1;
			if (applied_goal_q[j] != raw_goal_q[j]) changed_c = 1'b1;
		end
	end

	assign diff_c     = 17'(goal_c[j_q]) - 17'(blend_start_q[j_q]);
	assign diff_mag_c = diff_c[16] ? 17'(-diff_c) : 17'(diff_c);
	assign perr_c     = 17'(want_pos_q[j_q]) - 17'(last_pos_q[j_q]);
	assign verr_c     = 17'(want_vel_q[j_q]) - 17'(last_vel_q[j_q]);
	assign tgt_clamp_c = (in_tgt_q[j_q] < -DEG_LIMIT) ? -DEG_LIMIT :
	                     (in_tgt_q[j_q] >  DEG_LIMIT) ?  DEG_LIMIT : in_tgt_q[j_q];
	assign speed_c    = (speed_q == '0) ? 15'd1 : speed_q;
	assign tick_restart_c = changed_c || !blend_on_q;
	assign rs_return_c    = (act_q == ACT_TICK) ? S_RB_CHK : S_FIN;

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (s_axis_tvalid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (act_q)
					ACT_TICK: begin
						if (!enable_q) state_d = S_ELAPSE;
						else begin
							unique case (mode_q)
								MODE_HOLD:   state_d = blend_on_q ? S_RB_CHK : S_TQ;
								MODE_FOLLOW: state_d = S_M2;
								default:     state_d = S_ELAPSE;
							endcase
						end
					end
					ACT_MODE: begin
						if (req_q == 3'(MODE_HOLD) && req_q != {1'b0, mode_q})
							state_d = S_RS_START;
						else
							state_d = S_FIN;
					end
					ACT_TARGET: state_d = (mode_q == MODE_FOLLOW && enable_q) ? S_CV : S_FIN;
					default:    state_d = S_FIN;
				endcase
			end
			S_M2: begin
				if (goal_seen_q) state_d = tick_restart_c ? S_RS_START : S_RB_CHK;
				else             state_d = S_TQ;
			end
			S_RS_START: state_d = (disp_c == '0) ? rs_return_c : S_RS_DIV;
			S_RS_DIV:   state_d = S_RS_WAIT;
			S_RS_WAIT:  if (div_rsp.done) state_d = rs_return_c;
			S_RB_CHK:   state_d = (elapsed_q >= len_q) ? S_TQ : S_RB_TWAIT;
			S_RB_TWAIT: if (div_rsp.done) state_d = S_RB_T2;
			S_RB_T2:    state_d = S_RB_S;
			S_RB_S:     state_d = S_RB_S2;
			S_RB_S2:    state_d = S_RB_DS;
			S_RB_DS:    state_d = S_RB_P;
			S_RB_P:     state_d = S_RB_PW;
			S_RB_PW:    state_d = S_RB_V1;
			S_RB_V1:    state_d = S_RB_V2;
			S_RB_V2:    state_d = S_RB_V3;
			S_RB_V3:    if (div_rsp.done) state_d = j_last ? S_TQ : S_RB_P;
			S_TQ:       state_d = S_TQ2;
			S_TQ2:      state_d = S_TQ3;
			S_TQ3:      state_d = j_last ? S_ELAPSE : S_TQ;
			S_CV:       state_d = S_CV2;
			S_CV2:      state_d = j_last ? S_FIN : S_CV;
			S_ELAPSE:   state_d = S_FIN;
			S_FIN:      if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------ unit operands
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = len_q;
		unique case (state_q)
			S_RS_START: begin
				mul_a = MUL_AW'(disp_c);
				mul_b = MUL_BW'(ONE_MILLION);
			end
			S_RS_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = mul_p[DIV_NW-1:0];
				div_req.den   = DIV_DW'(speed_c);
			end
			S_RB_CHK: begin
				div_req.start = (elapsed_q < len_q);
				div_req.num   = DIV_NW'({elapsed_q, 16'd0});
			end
			S_RB_T2: begin
				mul_a = MUL_AW'(t_q);
				mul_b = MUL_BW'(t_q);
			end
			S_RB_S: begin
				mul_a = MUL_AW'(mul_p[31:0]);
				mul_b = MUL_BW'(SMOOTH_K - {1'b0, t_q, 1'b0});
			end
			S_RB_S2: begin
				mul_a = MUL_AW'(t_q);
				mul_b = MUL_BW'(17'h10000 - {1'b0, t_q});
			end
			S_RB_P: begin
				mul_a = MUL_AW'(diff_c);
				mul_b = MUL_BW'(s_q);
			end
			S_RB_PW: begin
				mul_a = MUL_AW'(diff_mag_c);
				mul_b = MUL_BW'(ds_q);
			end
			S_RB_V1: begin
				mul_a = MUL_AW'(mul_p[34:0]);
				mul_b = MUL_BW'(ONE_MILLION);
			end
			S_RB_V2: begin
				// floor(n*1e6 / (len*65536)) = floor(floor(n*1e6 / 65536) / len)
				div_req.start = 1'b1;
				div_req.num   = mul_p[DIV_NW+15:16];
			end
			S_TQ: begin
				mul_a = MUL_AW'(perr_c);
				mul_b = MUL_BW'(kp_q[j_q]);
			end
			S_TQ2: begin
				mul_a = MUL_AW'(verr_c);
				mul_b = MUL_BW'(kd_q[j_q]);
			end
			S_CV: begin
				mul_a = MUL_AW'(tgt_clamp_c);
				mul_b = MUL_BW'(DEG_TO_RAD);
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------- state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// -------------------------------------------------- datapath registers
	logic [TIME_W:0]    elapsed_sum;
	logic signed [36:0] tq_sum;
	logic signed [28:0] tq_shr;
	logic signed [20:0] pos_sum;
	logic [33:0]        ds_wide;
	logic signed [15:0] vel_sat;

	assign elapsed_sum = {1'b0, elapsed_q} + (TIME_W + 1)'(period_q);
	assign tq_sum      = 37'(pp_q) + 37'(signed'(mul_p[35:0]));
	assign tq_shr      = tq_sum[36:8];
	assign pos_sum     = 21'(blend_start_q[j_q]) + 21'(signed'(mul_p[35:16]));
	assign ds_wide     = {1'b0, mul_p[30:0], 2'b0} + {2'b0, mul_p[30:0], 1'b0};

	always_comb begin
		if (diff_c[16])
			vel_sat = (div_rsp.quo >= DIV_NW'(32768)) ? -16'sd32768
			                                          : 16'(-div_rsp.quo[15:0]);
		else
			vel_sat = (div_rsp.quo > DIV_NW'(32767)) ? 16'sd32767
			                                         : signed'(div_rsp.quo[15:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q            <= '0;
			mode_q         <= MODE_OFF;
			blend_on_q     <= 1'b0;
			hold_latched_q <= 1'b0;
			goal_seen_q    <= 1'b0;
			len_q          <= '0;
			elapsed_q      <= '0;
			res_drive_q    <= 1'b0;
			res_acc_q      <= 1'b0;
			res_clip_q     <= 1'b0;
			for (int j = 0; j < JOINTS; j++) begin
				hold_pos_q[j]     <= '0;
				raw_goal_q[j]     <= '0;
				applied_goal_q[j] <= '0;
				want_pos_q[j]     <= '0;
				want_vel_q[j]     <= '0;
				blend_start_q[j]  <= '0;
				last_pos_q[j]     <= '0;
				last_vel_q[j]     <= '0;
				res_tq_q[j]       <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						res_drive_q <= 1'b0;
						res_acc_q   <= 1'b0;
						res_clip_q  <= 1'b0;
						for (int j = 0; j < JOINTS; j++) res_tq_q[j] <= '0;
					end
				end
				S_DECODE: begin
					unique case (act_q)
						ACT_TICK: begin
							if (enable_q) begin
								for (int j = 0; j < JOINTS; j++) begin
									last_pos_q[j] <= in_pos_q[j];
									last_vel_q[j] <= in_vel_q[j];
								end
								unique case (mode_q)
									MODE_HOLD: begin
										res_drive_q <= 1'b1;
										if (!blend_on_q && hold_latched_q)
											for (int j = 0; j < JOINTS; j++) begin
												want_pos_q[j] <= hold_pos_q[j];
												want_vel_q[j] <= '0;
											end
									end
									MODE_FOLLOW: res_drive_q <= 1'b1;
									default:     blend_on_q  <= 1'b0;
								endcase
							end
						end
						ACT_MODE: begin
							if (req_q <= 3'(MODE_FOLLOW)) begin
								res_acc_q <= 1'b1;
								if (req_q != {1'b0, mode_q}) begin
									mode_q <= mode_t'(req_q[1:0]);
									unique case (mode_t'(req_q[1:0]))
										MODE_HOLD: begin
											if (!hold_latched_q) begin
												for (int j = 0; j < JOINTS; j++)
													hold_pos_q[j] <= last_pos_q[j];
												hold_latched_q <= 1'b1;
											end
											blend_on_q <= 1'b1;
										end
										MODE_OFF: blend_on_q <= 1'b0;
										default: begin
											if (any_last_c)
												for (int j = 0; j < JOINTS; j++) begin
													want_pos_q[j] <= last_pos_q[j];
													want_vel_q[j] <= last_vel_q[j];
												end
											blend_on_q  <= 1'b1;
											goal_seen_q <= 1'b0;
										end
									endcase
								end
							end
						end
						ACT_TARGET: begin
							if (mode_q == MODE_FOLLOW && enable_q) begin
								goal_seen_q <= 1'b1;
								res_acc_q   <= 1'b1;
							end
						end
						default: begin
							blend_on_q     <= 1'b0;
							hold_latched_q <= 1'b0;
							goal_seen_q    <= 1'b0;
							for (int j = 0; j < JOINTS; j++) begin
								want_pos_q[j] <= last_pos_q[j];
								want_vel_q[j] <= last_vel_q[j];
							end
						end
					endcase
				end
				S_M2: begin
					if (goal_seen_q) begin
						if (tick_restart_c) begin
							// seed the blend from the measurement when nothing is commanded
							if (!any_want_c && any_last_c)
								for (int j = 0; j < JOINTS; j++) begin
									want_pos_q[j] <= last_pos_q[j];
									want_vel_q[j] <= last_vel_q[j];
								end
							for (int j = 0; j < JOINTS; j++)
								applied_goal_q[j] <= raw_goal_q[j];
							blend_on_q <= 1'b1;
						end
					end else begin
						for (int j = 0; j < JOINTS; j++) begin
							if (!any_want_c && any_last_c) want_pos_q[j] <= last_pos_q[j];
							want_vel_q[j] <= '0;
						end
					end
				end
				S_RS_START: begin
					elapsed_q <= '0;
					for (int j = 0; j < JOINTS; j++) blend_start_q[j] <= rst_start_c[j];
					if (disp_c == '0) len_q <= '0;
				end
				S_RS_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.quo < DIV_NW'(LEN_MIN))      len_q <= LEN_MIN;
						else if (div_rsp.quo > DIV_NW'(LEN_MAX)) len_q <= LEN_MAX;
						else                                     len_q <= div_rsp.quo[TIME_W-1:0];
					end
				end
				S_RB_CHK: begin
					// blend time is up: land on the goal and stop
					if (elapsed_q >= len_q) begin
						for (int j = 0; j < JOINTS; j++) begin
							want_pos_q[j] <= goal_c[j];
							want_vel_q[j] <= '0;
						end
						blend_on_q <= 1'b0;
					end
				end
				S_RB_TWAIT: if (div_rsp.done) t_q <= div_rsp.quo[15:0];
				S_RB_S2:    s_q  <= mul_p[49:32];
				S_RB_DS:    ds_q <= ds_wide[32:16];
				S_RB_PW: begin
					if (pos_sum > 21'sd32767)       want_pos_q[j_q] <= 16'sd32767;
					else if (pos_sum < -21'sd32768) want_pos_q[j_q] <= -16'sd32768;
					else                            want_pos_q[j_q] <= pos_sum[15:0];
				end
				S_RB_V3: begin
					if (div_rsp.done) begin
						want_vel_q[j_q] <= vel_sat;
						j_q <= j_last ? '0 : j_q + 1'b1;
					end
				end
				S_TQ2: pp_q <= mul_p[35:0];
				S_TQ3: begin
					if (37'(tq_shr) > 37'sd2147483647) begin
						res_tq_q[j_q] <= 32'sh7fffffff;
						res_clip_q    <= 1'b1;
					end else if (37'(tq_shr) < -37'sd2147483648) begin
						res_tq_q[j_q] <= 32'sh80000000;
						res_clip_q    <= 1'b1;
					end else begin
						res_tq_q[j_q] <= 32'(tq_shr);
					end
					j_q <= j_last ? '0 : j_q + 1'b1;
				end
				S_CV2: begin
					raw_goal_q[j_q] <= 16'((mul_p[33:0] + 34'sd32768) >>> 16);
					j_q <= j_last ? '0 : j_q + 1'b1;
				end
				S_ELAPSE: begin
					// time runs on every tick, saturating
					elapsed_q <= (elapsed_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX
					                                                : elapsed_sum[TIME_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// capture the input transaction
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			act_q <= action_t'(s_axis_tuser);
			req_q <= s_axis_tdata[2:0];
			for (int j = 0; j < JOINTS; j++) begin
				in_pos_q[j] <= s_axis_tdata[3 + 16*j +: 16];
				in_vel_q[j] <= s_axis_tdata[35 + 16*j +: 16];
				in_tgt_q[j] <= s_axis_tdata[67 + 16*j +: 16];
			end
		end
	end

	// ------------------------------------------------------- output register
	logic [63:0] res_data_c;

	always_comb begin
		res_data_c = '0;
		for (int j = 0; j < JOINTS; j++) res_data_c[32*j +: 32] = res_tq_q[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= res_data_c;
			m_axis_tuser <= {res_clip_q, blend_on_q, res_acc_q, res_drive_q};
		end
	end

endmodule

`default_nettype wire
